// ===== rtl/rmbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rmbp_pkg
// Shared types and constants for the RESP multibulk request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rmbp_pkg;

  localparam int LENGTH_BITS  = 30;
  localparam int BULK_W       = 30;
  localparam int COUNT_W      = 16;
  localparam int LINE_W       = 8;
  localparam int CFG_W        = 30;
  localparam int CFG_IDX_W    = 2;
  localparam int ACC_W        = 32;
  localparam int ARGS_W       = 17;

  localparam logic [ACC_W-1:0] LEN_MASK =
    ACC_W'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [LENGTH_BITS-1:0] TRAILER_LEN = LENGTH_BITS'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BULK_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_ARG_END   = 3'd1,
    KIND_EMPTY     = 3'd2,
    KIND_PARSE_ERR = 3'd3,
    KIND_TOO_LARGE = 3'd4,
    KIND_INLINE    = 3'd5
  } kind_t;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_COUNT   = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_TRAILER = 6'b010000,
    PH_WAIT    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] max_arg_count;
    logic [BULK_W-1:0]  max_bulk_length;
    logic [LINE_W-1:0]  max_line_length;
  } cfg_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             payload_byte;
    logic [COUNT_W-1:0]     arg_index;
    logic [LENGTH_BITS-1:0] arg_length;
    logic                   last_of_command;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/rmbp_parser.sv =====
// ----------------------------------------------------------------------------
// rmbp_parser
// Parse state and one-byte step: count/length lines, payload and trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module rmbp_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic [7:0]       step_byte,
  input  wire rmbp_pkg::cfg_t   cfg,
  output logic                  res_valid,
  output rmbp_pkg::result_t     res
);
  import rmbp_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [ARGS_W-1:0]      args_rem_r, args_rem_nxt;
  logic [COUNT_W-1:0]     arg_cnt_r, arg_cnt_nxt;
  logic [LENGTH_BITS-1:0] bytes_rem_r, bytes_rem_nxt;
  logic [LENGTH_BITS-1:0] cur_len_r, cur_len_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ended_r, ended_nxt;
  logic                   started_r, started_nxt;
  logic [LINE_W-1:0]      line_cnt_r, line_cnt_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   held_valid_r, held_valid_nxt;

  // Digit feed of the held byte; independent of the incoming byte.
  // acc * 10 + 9 needs four bits above the accumulator.
  logic [ACC_W+3:0] acc_x10;
  logic [ACC_W-1:0] f_acc;
  logic             f_neg, f_ended, f_started;
  logic             held_digit;

  always_comb begin
    held_digit = (held_r >= CH_ZERO) && (held_r <= CH_NINE);
    acc_x10 = ({4'b0000, acc_r} << 3) + ({4'b0000, acc_r} << 1)
            + {ACC_W'(0), held_r[3:0]};
    f_acc     = acc_r;
    f_neg     = neg_r;
    f_ended   = ended_r;
    f_started = started_r;
    if (!ended_r) begin
      if (held_digit) begin
        f_acc     = (acc_x10[ACC_W+3:ACC_W] != 4'b0000) ? '1 : acc_x10[ACC_W-1:0];
        f_started = 1'b1;
      end else if (!started_r && (held_r == CH_PLUS || held_r == CH_MINUS)) begin
        f_neg     = (held_r == CH_MINUS);
        f_started = 1'b1;
      end else begin
        f_ended = 1'b1;
      end
    end
  end

  logic line_too_long;
  logic acc_too_big;
  logic last_arg;
  logic [LENGTH_BITS-1:0] br_dec;

  always_comb begin
    line_too_long = line_cnt_r >= cfg.max_line_length;
    acc_too_big   = (acc_r > {(ACC_W - BULK_W)'(0), cfg.max_bulk_length}) ||
                    (acc_r > LEN_MASK);
    last_arg      = args_rem_r <= ARGS_W'(1);
    br_dec        = bytes_rem_r - LENGTH_BITS'(1);

    phase_nxt      = phase_r;
    args_rem_nxt   = args_rem_r;
    arg_cnt_nxt    = arg_cnt_r;
    bytes_rem_nxt  = bytes_rem_r;
    cur_len_nxt    = cur_len_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    ended_nxt      = ended_r;
    started_nxt    = started_r;
    line_cnt_nxt   = line_cnt_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;

    res_valid = 1'b0;
    res       = '0;

    // begin-of-line and line-byte updates, applied by the phase logic below
    unique case (phase_r)
      PH_IDLE: begin
        if (step_byte == CH_STAR) begin
          acc_nxt = '0; neg_nxt = 1'b0; ended_nxt = 1'b0; started_nxt = 1'b0;
          held_valid_nxt = 1'b0; held_nxt = '0; line_cnt_nxt = LINE_W'(1);
          phase_nxt = PH_COUNT;
        end else begin
          phase_nxt = PH_WAIT;
          res_valid = 1'b1;
          res.kind  = KIND_INLINE;
        end
      end

      PH_COUNT, PH_LEN: begin
        if (phase_r == PH_LEN && line_cnt_r == '0) begin
          if (step_byte != CH_DOLLAR) begin
            phase_nxt = PH_WAIT;
            res_valid = 1'b1;
            res.kind  = KIND_PARSE_ERR;
          end else begin
            acc_nxt = '0; neg_nxt = 1'b0; ended_nxt = 1'b0; started_nxt = 1'b0;
            held_valid_nxt = 1'b0; held_nxt = '0; line_cnt_nxt = LINE_W'(1);
          end
        end else if (step_byte != CH_LF) begin
          if (line_too_long) begin
            phase_nxt = PH_WAIT;
            res_valid = 1'b1;
            res.kind  = KIND_TOO_LARGE;
          end else begin
            line_cnt_nxt = line_cnt_r + LINE_W'(1);
            if (held_valid_r) begin
              acc_nxt     = f_acc;
              neg_nxt     = f_neg;
              ended_nxt   = f_ended;
              started_nxt = f_started;
            end
            held_nxt       = step_byte;
            held_valid_nxt = 1'b1;
          end
        end else if (phase_r == PH_COUNT) begin
          if (neg_r || acc_r == '0) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
          end else if (acc_r > {(ACC_W - COUNT_W)'(0), cfg.max_arg_count}) begin
            phase_nxt = PH_WAIT;
            res_valid = 1'b1;
            res.kind  = KIND_TOO_LARGE;
          end else begin
            args_rem_nxt = acc_r[ARGS_W-1:0];
            arg_cnt_nxt  = '0;
            line_cnt_nxt = '0;
            phase_nxt    = PH_LEN;
          end
        end else begin
          // end of a length line; "-0" is a valid zero length
          if (neg_r && acc_r != '0) begin
            phase_nxt = PH_WAIT;
            res_valid = 1'b1;
            res.kind  = KIND_PARSE_ERR;
          end else if (acc_too_big) begin
            phase_nxt = PH_WAIT;
            res_valid = 1'b1;
            res.kind  = KIND_TOO_LARGE;
          end else begin
            cur_len_nxt = acc_r[LENGTH_BITS-1:0];
            if (acc_r[LENGTH_BITS-1:0] != '0) begin
              bytes_rem_nxt = acc_r[LENGTH_BITS-1:0];
              phase_nxt     = PH_PAYLOAD;
            end else begin
              bytes_rem_nxt = TRAILER_LEN;
              phase_nxt     = PH_TRAILER;
            end
          end
        end
      end

      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_DATA;
        res.payload_byte = step_byte;
        res.arg_index    = arg_cnt_r;
        res.arg_length   = cur_len_r;
        if (br_dec == '0) begin
          bytes_rem_nxt = TRAILER_LEN;
          phase_nxt     = PH_TRAILER;
        end else begin
          bytes_rem_nxt = br_dec;
        end
      end

      PH_TRAILER: begin
        bytes_rem_nxt = br_dec;
        if (br_dec == '0) begin
          res_valid           = 1'b1;
          res.kind            = KIND_ARG_END;
          res.arg_index       = arg_cnt_r;
          res.arg_length      = cur_len_r;
          res.last_of_command = last_arg;
          args_rem_nxt        = args_rem_r - ARGS_W'(1);
          arg_cnt_nxt         = arg_cnt_r + COUNT_W'(1);
          if (last_arg) begin
            phase_nxt = PH_IDLE;
          end else begin
            line_cnt_nxt = '0;
            phase_nxt    = PH_LEN;
          end
        end
      end

      default: begin
        // waiting phase, and any corrupt phase code
        phase_nxt = PH_WAIT;
        if (step_byte == CH_STAR) begin
          acc_nxt = '0; neg_nxt = 1'b0; ended_nxt = 1'b0; started_nxt = 1'b0;
          held_valid_nxt = 1'b0; held_nxt = '0; line_cnt_nxt = LINE_W'(1);
          phase_nxt = PH_COUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      args_rem_r   <= '0;
      arg_cnt_r    <= '0;
      bytes_rem_r  <= '0;
      cur_len_r    <= '0;
      acc_r        <= '0;
      neg_r        <= 1'b0;
      ended_r      <= 1'b0;
      started_r    <= 1'b0;
      line_cnt_r   <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      args_rem_r   <= args_rem_nxt;
      arg_cnt_r    <= arg_cnt_nxt;
      bytes_rem_r  <= bytes_rem_nxt;
      cur_len_r    <= cur_len_nxt;
      acc_r        <= acc_nxt;
      neg_r        <= neg_nxt;
      ended_r      <= ended_nxt;
      started_r    <= started_nxt;
      line_cnt_r   <= line_cnt_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/resp_multibulk_request_parser_core.sv =====
// ----------------------------------------------------------------------------
// resp_multibulk_request_parser_core
// RESP multibulk request parser: byte stream in, payload/event results out.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | in_data_byte
//   out_    | output    | out_valid / out_ready  | kind, payload_byte, arg_index,
//           |           |                        | arg_length, last_of_command
//   cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// One byte per cycle sustained while the output is not stalled: a byte is
// registered in the input stage, parsed when the output register can take a
// result, and its result (if any) lands in the output register.
// The parse step only advances while the output register is empty or being
// drained, so a stalled output backs up into in_ready after one byte.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_multibulk_request_parser_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         in_data_byte,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [2:0]                              out_kind,
  output logic [7:0]                              out_payload_byte,
  output logic [rmbp_pkg::COUNT_W-1:0]            out_arg_index,
  output logic [rmbp_pkg::LENGTH_BITS-1:0]        out_arg_length,
  output logic                                    out_last_of_command,
  input  wire logic                               cfg_we,
  input  wire logic [rmbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rmbp_pkg::CFG_W-1:0]         cfg_data
);
  import rmbp_pkg::*;

  cfg_t       cfg_r;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       step_en;
  logic       res_valid;
  result_t    res;

  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_arg_count   <= COUNT_W'(1024);
      cfg_r.max_bulk_length <= BULK_W'(65534);
      cfg_r.max_line_length <= LINE_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ARG_COUNT:   cfg_r.max_arg_count   <= cfg_data[COUNT_W-1:0];
        CFG_MAX_BULK_LENGTH: cfg_r.max_bulk_length <= cfg_data[BULK_W-1:0];
        CFG_MAX_LINE_LENGTH: cfg_r.max_line_length <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
    end
  end

  rmbp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_byte (in_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_r.kind;
  assign out_payload_byte    = out_r.payload_byte;
  assign out_arg_index       = out_r.arg_index;
  assign out_arg_length      = out_r.arg_length;
  assign out_last_of_command = out_r.last_of_command;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RESP multibulk request parser core: drives
// byte streams of well-formed, broken and noisy commands under several limit
// settings, predicts every result in a cycle-free parser model, and checks
// each output transaction in order with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import rmbp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0]           CH_CR      = 8'h0D;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_data_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [2:0]             out_kind;
  logic [7:0]             out_payload_byte;
  logic [COUNT_W-1:0]     out_arg_index;
  logic [LENGTH_BITS-1:0] out_arg_length;
  logic                   out_last_of_command;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  resp_multibulk_request_parser_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_arg_index       (out_arg_index),
    .out_arg_length      (out_arg_length),
    .out_last_of_command (out_last_of_command),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  cfg_t                   limits;
  phase_t                 ph;
  logic [ARGS_W-1:0]      args_left;
  logic [COUNT_W-1:0]     arg_idx;
  logic [LENGTH_BITS-1:0] bytes_left;
  logic [LENGTH_BITS-1:0] cur_len;
  logic [ACC_W-1:0]       acc;
  logic                   neg_sign;
  logic                   digits_done;
  logic [LINE_W-1:0]      line_cnt;
  logic                   num_started;
  logic [7:0]             held_byte;
  logic                   held_ok;

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      bytes_sent = 0;
  bit      tx_gaps = 1'b1;
  bit      rx_gaps = 1'b1;
  int      rx_hold_cycles = 0;

  function automatic void reset_model();
    limits.max_arg_count   = 16'd1024;
    limits.max_bulk_length = 30'd65534;
    limits.max_line_length = 8'd32;
    ph          = PH_IDLE;
    args_left   = '0;
    arg_idx     = '0;
    bytes_left  = '0;
    cur_len     = '0;
    acc         = '0;
    neg_sign    = 1'b0;
    digits_done = 1'b0;
    line_cnt    = '0;
    num_started = 1'b0;
    held_byte   = '0;
    held_ok     = 1'b0;
  endfunction

  function automatic void start_line();
    acc         = '0;
    neg_sign    = 1'b0;
    digits_done = 1'b0;
    num_started = 1'b0;
    held_ok     = 1'b0;
    held_byte   = '0;
    line_cnt    = 8'd1;
  endfunction

  function automatic void take_digit(logic [7:0] c);
    logic [63:0] t;
    if (digits_done) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = {32'd0, acc} * 64'd10 + {56'd0, c - CH_ZERO};
      acc = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
      num_started = 1'b1;
    end else if (!num_started && (c == CH_PLUS || c == CH_MINUS)) begin
      neg_sign    = (c == CH_MINUS);
      num_started = 1'b1;
    end else begin
      digits_done = 1'b1;
    end
  endfunction

  // One byte is held back so the byte in front of the newline never counts.
  function automatic logic line_overflow(logic [7:0] c);
    if (line_cnt >= limits.max_line_length) return 1'b1;
    line_cnt = line_cnt + 8'd1;
    if (held_ok) take_digit(held_byte);
    held_byte = c;
    held_ok   = 1'b1;
    return 1'b0;
  endfunction

  function automatic void predict_parse(logic [7:0] c);
    result_t r;
    logic    hit;
    r   = '0;
    hit = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (c == CH_STAR) begin
          start_line();
          ph = PH_COUNT;
        end else begin
          ph     = PH_WAIT;
          r.kind = KIND_INLINE;
          hit    = 1'b1;
        end
      end
      PH_COUNT: begin
        if (c != CH_LF) begin
          if (line_overflow(c)) begin
            ph     = PH_WAIT;
            r.kind = KIND_TOO_LARGE;
            hit    = 1'b1;
          end
        end else if (neg_sign || acc == '0) begin
          ph     = PH_IDLE;
          r.kind = KIND_EMPTY;
          hit    = 1'b1;
        end else if (acc > ACC_W'(limits.max_arg_count)) begin
          ph     = PH_WAIT;
          r.kind = KIND_TOO_LARGE;
          hit    = 1'b1;
        end else begin
          args_left = acc[ARGS_W-1:0];
          arg_idx   = '0;
          line_cnt  = '0;
          ph        = PH_LEN;
        end
      end
      PH_LEN: begin
        if (line_cnt == '0) begin
          if (c != CH_DOLLAR) begin
            ph     = PH_WAIT;
            r.kind = KIND_PARSE_ERR;
            hit    = 1'b1;
          end else begin
            start_line();
          end
        end else if (c != CH_LF) begin
          if (line_overflow(c)) begin
            ph     = PH_WAIT;
            r.kind = KIND_TOO_LARGE;
            hit    = 1'b1;
          end
        end else if (neg_sign && acc != '0) begin
          ph     = PH_WAIT;
          r.kind = KIND_PARSE_ERR;
          hit    = 1'b1;
        end else if (acc > ACC_W'(limits.max_bulk_length) || acc > LEN_MASK) begin
          ph     = PH_WAIT;
          r.kind = KIND_TOO_LARGE;
          hit    = 1'b1;
        end else begin
          cur_len = acc[LENGTH_BITS-1:0];
          if (cur_len != '0) begin
            bytes_left = cur_len;
            ph         = PH_PAYLOAD;
          end else begin
            bytes_left = TRAILER_LEN;
            ph         = PH_TRAILER;
          end
        end
      end
      PH_PAYLOAD: begin
        r.kind         = KIND_DATA;
        r.payload_byte = c;
        r.arg_index    = arg_idx;
        r.arg_length   = cur_len;
        hit            = 1'b1;
        bytes_left     = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          bytes_left = TRAILER_LEN;
          ph         = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          r.kind            = KIND_ARG_END;
          r.arg_index       = arg_idx;
          r.arg_length      = cur_len;
          r.last_of_command = (args_left <= 17'd1);
          hit               = 1'b1;
          args_left         = args_left - 1'b1;
          arg_idx           = arg_idx + 1'b1;
          if (r.last_of_command) begin
            ph = PH_IDLE;
          end else begin
            line_cnt = '0;
            ph       = PH_LEN;
          end
        end
      end
      default: begin
        ph = PH_WAIT;
        if (c == CH_STAR) begin
          start_line();
          ph = PH_COUNT;
        end
      end
    endcase
    if (hit) pending_results.insert(pending_results.size(), r);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void flag_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch (%s): expected kind=%0d byte=%02h idx=%0d len=%0d last=%0b",
               $time, what, want.kind, want.payload_byte, want.arg_index,
               want.arg_length, want.last_of_command);
    if (mismatch_count <= 10)
      $display("    got kind=%0d byte=%02h idx=%0d len=%0d last=%0b",
               got.kind, got.payload_byte, got.arg_index, got.arg_length,
               got.last_of_command);
  endfunction

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_parse(in_data_byte);
      if (out_valid && out_ready) begin
        got.kind            = kind_t'(out_kind);
        got.payload_byte    = out_payload_byte;
        got.arg_index       = out_arg_index;
        got.arg_length      = out_arg_length;
        got.last_of_command = out_last_of_command;
        if (pending_results.size() == 0) begin
          flag_mismatch("no result expected", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.arg_index !== want.arg_index || got.arg_length !== want.arg_length ||
              got.last_of_command !== want.last_of_command)
            flag_mismatch("field", want, got);
        end
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  initial begin : ready_driver
    int hold;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        hold           = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        out_ready <= !(rx_gaps && $urandom_range(0, 99) < 18);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while (tx_gaps && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Input idle until every predicted result is out, plus pipeline latency.
  task automatic drain_results();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [COUNT_W-1:0] arg_cap,
                            input logic [BULK_W-1:0] bulk_cap,
                            input logic [LINE_W-1:0] line_cap);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ARG_COUNT;
    cfg_data  <= CFG_W'(arg_cap);
    @(posedge clk);
    limits.max_arg_count = arg_cap;
    cfg_index <= CFG_MAX_BULK_LENGTH;
    cfg_data  <= bulk_cap;
    @(posedge clk);
    limits.max_bulk_length = bulk_cap;
    cfg_index <= CFG_MAX_LINE_LENGTH;
    cfg_data  <= CFG_W'(line_cap);
    @(posedge clk);
    limits.max_line_length = line_cap;
    // unmapped index must leave every limit alone
    cfg_index <= CFG_UNUSED;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom);
    return (b == CH_LF) ? CH_CR : b;
  endfunction

  function automatic logic [7:0] pick_tail();
    return ($urandom_range(0, 7) == 0) ? any_but_lf() : CH_CR;
  endfunction

  // prefix, optional sign, leading zeros, digits (none if value < 0),
  // optional non-digit junk, the dropped byte, newline
  task automatic send_number_line(input logic [7:0] prefix, input logic [7:0] sign,
                                  input longint value, input int zeros,
                                  input logic junk, input logic [7:0] tail);
    logic [7:0]      digs[20];
    int              n;
    longint unsigned v;
    logic [7:0]      j;
    n = 0;
    send_byte(prefix);
    if (sign != 8'h00) send_byte(sign);
    repeat (zeros) send_byte(CH_ZERO);
    if (value >= 0) begin
      v = value;
      do begin
        digs[n] = CH_ZERO + 8'(v % 10);
        n++;
        v = v / 10;
      end while (v != 0);
      for (int i = n - 1; i >= 0; i--) send_byte(digs[i]);
    end
    if (junk) begin
      j = any_but_lf();
      if (j >= CH_ZERO && j <= CH_NINE) j = 8'h20;
      send_byte(j);
    end
    send_byte(tail);
    send_byte(CH_LF);
  endtask

  task automatic send_command(input int max_args, input int max_len);
    int         roll;
    int         n_args;
    int         len;
    int         cap;
    logic [7:0] b;
    logic [7:0] sgn;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      // empty command: zero, negative, or no digits at all
      case ($urandom_range(0, 3))
        0: send_number_line(CH_STAR, 8'h00, 0, 0, 1'b0, pick_tail());
        1: send_number_line(CH_STAR, CH_MINUS, $urandom_range(0, 99), 0, 1'b0, pick_tail());
        2: send_number_line(CH_STAR, CH_PLUS, 0, 0, 1'b0, pick_tail());
        default: send_number_line(CH_STAR, 8'h00, -1, 0, 1'b0, pick_tail());
      endcase
      return;
    end
    if (roll < 10) begin
      if ($urandom_range(0, 3) == 0)
        send_number_line(CH_STAR, 8'h00, 64'd99999999999, 0, 1'b0, pick_tail());
      else
        send_number_line(CH_STAR, 8'h00,
                         longint'(limits.max_arg_count) + 1 + $urandom_range(0, 100),
                         0, 1'b0, pick_tail());
      return;
    end
    if (roll < 14) begin
      repeat ($urandom_range(1, 6)) send_byte(any_but_lf());
      return;
    end
    if (roll < 15) begin
      send_number_line(CH_STAR, 8'h00, 1, limits.max_line_length, 1'b0, pick_tail());
      return;
    end
    cap    = (max_args < limits.max_arg_count) ? max_args : limits.max_arg_count;
    n_args = $urandom_range(1, cap);
    sgn    = ($urandom_range(0, 9) == 0) ? CH_PLUS : 8'h00;
    send_number_line(CH_STAR, sgn, n_args,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                     $urandom_range(0, 9) == 0, pick_tail());
    for (int a = 0; a < n_args; a++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        b = 8'($urandom);
        if (b == CH_DOLLAR) b = CH_LF;
        send_byte(b);
        return;
      end
      if (roll < 6) begin
        send_number_line(CH_DOLLAR, CH_MINUS, $urandom_range(1, 99), 0, 1'b0, pick_tail());
        return;
      end
      if (roll < 9) begin
        if ($urandom_range(0, 3) == 0)
          send_number_line(CH_DOLLAR, 8'h00, 64'd99999999999, 0, 1'b0, pick_tail());
        else
          send_number_line(CH_DOLLAR, 8'h00,
                           longint'(limits.max_bulk_length) + 1 + $urandom_range(0, 50),
                           0, 1'b0, pick_tail());
        return;
      end
      if (roll < 11) return;  // truncated command
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, max_len) : $urandom_range(0, 4);
      if (len > limits.max_bulk_length) len = limits.max_bulk_length;
      if (len == 0 && $urandom_range(0, 3) == 0)
        sgn = CH_MINUS;  // minus zero is a plain zero length
      else
        sgn = ($urandom_range(0, 9) == 0) ? CH_PLUS : 8'h00;
      send_number_line(CH_DOLLAR, sgn, len,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                       $urandom_range(0, 9) == 0, pick_tail());
      repeat (len) send_byte(8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        send_byte(8'($urandom));
        send_byte(8'($urandom));
      end else begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    end
  endtask

  task automatic run_random(input int budget, input int max_args, input int max_len);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_command(max_args, max_len);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_byte(8'h41);                                     // inline request
    send_byte(8'h00);                                     // dropped while waiting
    send_number_line(CH_STAR, 8'h00, 0, 0, 1'b0, CH_CR);  // empty command
    send_number_line(CH_STAR, CH_MINUS, 5, 0, 1'b0, CH_CR);
    send_number_line(CH_STAR, CH_PLUS, 2, 0, 1'b0, CH_CR);
    send_number_line(CH_DOLLAR, 8'h00, 0, 0, 1'b0, CH_CR);
    send_byte(8'hFF);                                     // trailer bytes are never checked
    send_byte(8'h00);
    send_number_line(CH_DOLLAR, 8'h00, 2, 0, 1'b1, 8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic test_random_defaults();
    run_random(300, 4, 12);
  endtask

  task automatic test_tight_limits();
    set_limits(16'd1, 30'd0, 8'd3);
    run_random(220, 3, 4);
  endtask

  task automatic test_wide_limits();
    set_limits(16'd65535, 30'd536870912, 8'd255);
    run_random(260, 6, 40);
  endtask

  task automatic test_mid_limits();
    set_limits(16'($urandom_range(2, 6)), 30'($urandom_range(1, 8)),
               8'($urandom_range(5, 10)));
    run_random(200, 8, 10);
  endtask

  task automatic test_back_pressure();
    set_limits(16'd1024, 30'd65534, 8'd32);
    tx_gaps        = 1'b0;
    rx_hold_cycles = 300;
    run_random(60, 3, 8);
    drain_results();
    tx_gaps = 1'b1;
  endtask

  task automatic test_no_gaps();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random(200, 4, 12);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_defaults();
    test_tight_limits();
    test_wide_limits();
    test_mid_limits();
    test_back_pressure();
    test_no_gaps();

    drain_results();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== resp_multibulk_request_parser_core.f =====
rtl/rmbp_pkg.sv
rtl/rmbp_parser.sv
rtl/resp_multibulk_request_parser_core.sv
tb/sv/tb_top.sv
